@@ design/qdc_pkg.sv @@
// Package for the clamped x4 quadrature decoder.
// Holds field widths, command and register codes, the shared structs and the phase table.
// It has no dependencies.
`default_nettype none

package qdc_pkg;

    localparam int CMD_W        = 2;
    localparam int LOAD_W       = 14;
    localparam int COUNT_W      = 16;
    localparam int POS_W        = 14;
    localparam int SET_W        = 2;
    localparam int HIT_W        = 2;
    localparam int SET_COUNT_W  = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int NUM_LIMITS   = 4;

    localparam int DEF_MAX_SETS       = 4;
    localparam int DEF_FILTER_SAMPLES = 4;

    localparam logic [SET_COUNT_W-1:0] SET_COUNT_RESET = 3'd1;
    localparam logic [COUNT_W-1:0]     LIMIT_RESET     = 16'd65532;
    localparam logic [1:0]             LAST_LIMIT      = 2'd3;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK = 2'd0,
        CMD_LOAD = 2'd1,
        CMD_NEXT = 2'd2
    } cmd_t;

    typedef enum logic [HIT_W-1:0] {
        HIT_NONE  = 2'd0,
        HIT_ZERO  = 2'd1,
        HIT_LIMIT = 2'd2
    } hit_t;

    typedef enum logic [1:0] {
        STEP_UP   = 2'd1,
        STEP_BAD  = 2'd2,
        STEP_DOWN = 2'd3
    } step_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SET_COUNT    = 3'd0,
        REG_LIMIT_ZERO   = 3'd1,
        REG_LIMIT_ONE    = 3'd2,
        REG_LIMIT_TWO    = 3'd3,
        REG_LIMIT_THREE  = 3'd4,
        REG_COUNT_ENABLE = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [SET_COUNT_W-1:0]                 set_count;
        logic [NUM_LIMITS-1:0][COUNT_W-1:0]     limit;
        logic                                   count_enable;
    } cfg_t;

    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] raw_count;
        logic [SET_W-1:0]   active_set;
        logic [HIT_W-1:0]   limit_hit;
    } result_t;

    // Position of a phase pair (A in bit 1) along the sequence 00, 10, 11, 01.
    function automatic logic [1:0] gray_pos(logic [1:0] ab);
        logic [1:0] pos;
        case (ab)
            2'b00:   pos = 2'd0;
            2'b10:   pos = 2'd1;
            2'b11:   pos = 2'd2;
            2'b01:   pos = 2'd3;
            default: pos = 2'd0;
        endcase
        return pos;
    endfunction

endpackage

`default_nettype wire

@@ design/qdc_in_if.sv @@
// Input channel of the quadrature decoder: valid, ready and one input item.
// Depends on qdc_pkg for the field widths.
`default_nettype none

interface qdc_in_if
    import qdc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic              phase_a;
    logic              phase_b;
    logic [LOAD_W-1:0] load_value;

    modport source (output valid, output command, output phase_a, output phase_b,
                    output load_value, input ready);
    modport sink   (input valid, input command, input phase_a, input phase_b,
                    input load_value, output ready);
endinterface

`default_nettype wire

@@ design/qdc_out_if.sv @@
// Result channel of the quadrature decoder: valid, ready and one result item.
// Depends on qdc_pkg for the field widths.
`default_nettype none

interface qdc_out_if
    import qdc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] raw_count;
    logic [SET_W-1:0]   active_set;
    logic [HIT_W-1:0]   limit_hit;

    modport source (output valid, output position, output raw_count, output active_set,
                    output limit_hit, input ready);
    modport sink   (input valid, input position, input raw_count, input active_set,
                    input limit_hit, output ready);
endinterface

`default_nettype wire

@@ design/qdc_filter.sv @@
// Debounce filter for one encoder phase: a level is taken after enough equal samples.
// Depends on nothing but its parameter.
`default_nettype none

module qdc_filter #(
    parameter int FILTER_SAMPLES = 4
) (
    input  logic clk,
    input  logic rst_n,
    input  logic sample_en,
    input  logic sample,
    output logic level,
    output logic level_next
);
    localparam int HIST_W = (FILTER_SAMPLES > 1) ? FILTER_SAMPLES - 1 : 1;
    localparam bit USE_HIST = (FILTER_SAMPLES > 1);

    logic [HIST_W-1:0] hist_reg;
    logic [HIST_W-1:0] hist_next;
    logic              level_reg;
    logic              all_ones;
    logic              all_zero;

    assign all_ones  = !USE_HIST || (&hist_reg);
    assign all_zero  = !USE_HIST || (hist_reg == '0);
    assign hist_next = HIST_W'({hist_reg, sample});

    always_comb
    begin
        level_next = level_reg;
        if (sample && all_ones)
        begin
            level_next = 1'b1;
        end
        else if (!sample && all_zero)
        begin
            level_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg  <= '0;
            level_reg <= 1'b0;
        end
        else if (sample_en)
        begin
            hist_reg  <= hist_next;
            level_reg <= level_next;
        end
    end

    assign level = level_reg;

endmodule

`default_nettype wire

@@ design/qdc_core.sv @@
// Decoder state and single-pass step logic: phase filters, set counts, clamping.
// Depends on qdc_pkg and qdc_filter.
`default_nettype none

module qdc_core
    import qdc_pkg::*;
#(
    parameter int MAX_SETS       = DEF_MAX_SETS,
    parameter int FILTER_SAMPLES = DEF_FILTER_SAMPLES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [CMD_W-1:0]  command,
    input  logic              phase_a,
    input  logic              phase_b,
    input  logic [LOAD_W-1:0] load_value,
    input  cfg_t              cfg,
    output result_t           res
);
    localparam int PTR_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int CMP_W = PTR_W + 2;

    logic [COUNT_W-1:0] counts_reg [MAX_SETS];
    logic [COUNT_W-1:0] cur_reg;
    logic [COUNT_W-1:0] cur_next;
    logic [PTR_W-1:0]   ptr_reg;
    logic [PTR_W-1:0]   ptr_next;
    logic               tick;
    logic               a_level;
    logic               a_next;
    logic               b_level;
    logic               b_next;
    logic [1:0]         old_ab;
    logic [1:0]         now_ab;
    logic [1:0]         step;
    logic [1:0]         lim_idx;
    logic [COUNT_W-1:0] lim;
    logic [COUNT_W:0]   sum;
    logic [COUNT_W-1:0] load_cnt;
    logic [CMP_W-1:0]   sc_ext;
    logic [CMP_W-1:0]   n_sets;
    logic [CMP_W-1:0]   ptr_inc;
    logic               store_en;
    hit_t               hit;

    assign tick = accept && (command == CMD_TICK);

    qdc_filter #(.FILTER_SAMPLES(FILTER_SAMPLES)) u_filter_a (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_en  (tick),
        .sample     (phase_a),
        .level      (a_level),
        .level_next (a_next)
    );

    qdc_filter #(.FILTER_SAMPLES(FILTER_SAMPLES)) u_filter_b (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_en  (tick),
        .sample     (phase_b),
        .level      (b_level),
        .level_next (b_next)
    );

    assign old_ab   = {a_level, b_level};
    assign now_ab   = {a_next, b_next};
    assign step     = 2'(gray_pos(now_ab) - gray_pos(old_ab));
    assign lim_idx  = (CMP_W'(ptr_reg) < CMP_W'(LAST_LIMIT)) ? 2'(ptr_reg) : LAST_LIMIT;
    assign lim      = cfg.limit[lim_idx];
    assign load_cnt = {load_value, 2'b00};
    assign sc_ext   = CMP_W'(cfg.set_count);
    assign ptr_inc  = CMP_W'(ptr_reg) + CMP_W'(1);

    always_comb
    begin
        if (sc_ext == '0)
        begin
            n_sets = CMP_W'(1);
        end
        else if (sc_ext > CMP_W'(MAX_SETS))
        begin
            n_sets = CMP_W'(MAX_SETS);
        end
        else
        begin
            n_sets = sc_ext;
        end
    end

    always_comb
    begin
        cur_next = cur_reg;
        ptr_next = ptr_reg;
        hit      = HIT_NONE;
        store_en = 1'b0;
        sum      = {1'b0, cur_reg};
        case (command)
            CMD_TICK:
            begin
                if ((now_ab != old_ab) && cfg.count_enable)
                begin
                    case (step)
                        STEP_UP:
                        begin
                            sum = {1'b0, cur_reg} + 17'd1;
                        end
                        STEP_DOWN:
                        begin
                            if (cur_reg == '0)
                            begin
                                hit = HIT_ZERO;
                            end
                            else
                            begin
                                sum = {1'b0, cur_reg} - 17'd1;
                            end
                        end
                        default:
                        begin
                            sum = {1'b0, cur_reg};
                        end
                    endcase
                    if ((step != STEP_BAD) && (sum > {1'b0, lim}))
                    begin
                        cur_next = lim;
                        hit      = HIT_LIMIT;
                    end
                    else
                    begin
                        cur_next = sum[COUNT_W-1:0];
                    end
                    store_en = 1'b1;
                end
            end
            CMD_LOAD:
            begin
                if (load_cnt > lim)
                begin
                    cur_next = lim;
                    hit      = HIT_LIMIT;
                end
                else
                begin
                    cur_next = load_cnt;
                end
                store_en = 1'b1;
            end
            CMD_NEXT:
            begin
                if (ptr_inc >= n_sets)
                begin
                    ptr_next = '0;
                end
                else
                begin
                    ptr_next = ptr_inc[PTR_W-1:0];
                end
                cur_next = counts_reg[ptr_next];
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= '0;
            ptr_reg <= '0;
            for (int i = 0; i < MAX_SETS; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            cur_reg <= cur_next;
            ptr_reg <= ptr_next;
            if (store_en)
            begin
                counts_reg[ptr_reg] <= cur_next;
            end
        end
    end

    assign res.position   = cur_next[COUNT_W-1:2];
    assign res.raw_count  = cur_next;
    assign res.active_set = SET_W'(ptr_next);
    assign res.limit_hit  = hit;

    // The active count is always mirrored in the stored count of its set.
    a_cur_mirrored: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg == counts_reg[ptr_reg])
        else $error("active count differs from stored count of active set");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(ptr_reg) < CMP_W'(MAX_SETS))
        else $error("set pointer beyond the number of sets");

    a_next_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (command == CMD_NEXT) |=>
            (ptr_reg == '0) || (ptr_reg == PTR_W'($past(ptr_reg) + 1'b1)))
        else $error("next command moved the set pointer wrongly");

    a_limit_hit: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (hit == HIT_LIMIT) |=> cur_reg == $past(lim))
        else $error("clamped count differs from the active limit");

    a_load_exact: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (command == CMD_LOAD) && (hit == HIT_NONE) |=>
            cur_reg == {$past(load_value), 2'b00})
        else $error("load without clamp did not store position times four");

endmodule

`default_nettype wire

@@ design/quadrature_decoder_clamped_top.sv @@
// Clamped x4 quadrature decoder: one result item for each accepted input item.
// The result and its valid flag are registered at the edge that accepts the item.
// Throughput: one item per cycle unless stalled; step logic is one pass from state to result.
// A new item is taken whenever the result register is empty or is being emptied.
// Reset (rst_n, asynchronous, active low) clears filters, set counts and pointer at once,
// and loads the register defaults; items are accepted as soon as reset is released.
`default_nettype none

module quadrature_decoder_clamped_top
    import qdc_pkg::*;
#(
    parameter int MAX_SETS       = DEF_MAX_SETS,
    parameter int FILTER_SAMPLES = DEF_FILTER_SAMPLES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    qdc_in_if.sink                phases,
    qdc_out_if.source             result
);
    cfg_t    cfg_reg;
    result_t res;
    result_t res_reg;
    logic    out_valid_reg;
    logic    accept;

    assign phases.ready = !out_valid_reg || result.ready;
    assign accept       = phases.valid && phases.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.set_count    <= SET_COUNT_RESET;
            cfg_reg.limit        <= {NUM_LIMITS{LIMIT_RESET}};
            cfg_reg.count_enable <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_SET_COUNT:    cfg_reg.set_count    <= cfg_data[SET_COUNT_W-1:0];
                REG_LIMIT_ZERO:   cfg_reg.limit[0]     <= cfg_data[COUNT_W-1:0];
                REG_LIMIT_ONE:    cfg_reg.limit[1]     <= cfg_data[COUNT_W-1:0];
                REG_LIMIT_TWO:    cfg_reg.limit[2]     <= cfg_data[COUNT_W-1:0];
                REG_LIMIT_THREE:  cfg_reg.limit[3]     <= cfg_data[COUNT_W-1:0];
                REG_COUNT_ENABLE: cfg_reg.count_enable <= cfg_data[0];
                default:
                begin
                    cfg_reg.count_enable <= cfg_reg.count_enable;
                end
            endcase
        end
    end

    qdc_core #(
        .MAX_SETS       (MAX_SETS),
        .FILTER_SAMPLES (FILTER_SAMPLES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .command    (phases.command),
        .phase_a    (phases.phase_a),
        .phase_b    (phases.phase_b),
        .load_value (phases.load_value),
        .cfg        (cfg_reg),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (phases.ready)
        begin
            out_valid_reg <= phases.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.position   = res_reg.position;
    assign result.raw_count  = res_reg.raw_count;
    assign result.active_set = res_reg.active_set;
    assign result.limit_hit  = res_reg.limit_hit;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the clamped x4 quadrature decoder: directed and random items
// through a queue-fed driver, results checked in order against an in-bench decoder model.
// Depends on qdc_pkg, qdc_in_if, qdc_out_if and quadrature_decoder_clamped_top.

module tb_top;
    import qdc_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 2;
    localparam int MAX_WAIT       = 8;
    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;
    localparam int HIST_W         = DEF_FILTER_SAMPLES - 1;
    localparam int LOAD_MAX       = (1 << LOAD_W) - 1;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic              phase_a;
        logic              phase_b;
        logic [LOAD_W-1:0] load_value;
    } phase_item_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic [CMD_W-1:0]      in_cmd = '0;
    logic                  in_a = 1'b0;
    logic                  in_b = 1'b0;
    logic [LOAD_W-1:0]     in_load = '0;
    logic                  out_ready = 1'b0;

    qdc_in_if  phases_if ();
    qdc_out_if result_if ();

    assign phases_if.valid      = in_valid;
    assign phases_if.command    = in_cmd;
    assign phases_if.phase_a    = in_a;
    assign phases_if.phase_b    = in_b;
    assign phases_if.load_value = in_load;
    assign result_if.ready      = out_ready;

    quadrature_decoder_clamped_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .phases    (phases_if),
        .result    (result_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Decoder model state and its copy of the registers.
    logic [HIST_W-1:0]  hist_a = '0;
    logic [HIST_W-1:0]  hist_b = '0;
    logic [1:0]         settled_ab = '0;
    logic [COUNT_W-1:0] count_store [NUM_LIMITS] = '{default: '0};
    logic [SET_W-1:0]   sel = '0;
    logic [2:0]         cfg_sets = SET_COUNT_RESET;
    logic [COUNT_W-1:0] cfg_limit [NUM_LIMITS] = '{default: LIMIT_RESET};
    logic               cfg_en = 1'b1;

    phase_item_t pending_items [$];
    result_t     expected_results [$];
    phase_item_t held_item;
    result_t     predicted;
    result_t     wanted;
    logic [1:0]  wheel_ab = '0;
    bit          holding = 0;
    bit          quiet_in = 0;
    bit          quiet_out = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    int          queued_items = 0;
    int          items_accepted = 0;
    int          results_seen = 0;
    int          mismatch_count = 0;
    int          zero_clamps = 0;
    int          limit_clamps = 0;
    int          setting_count = 1;
    int          stuck_cycles = 0;

    function automatic logic settle(input logic [HIST_W-1:0] hist, input logic sample,
                                    input logic level);
        if (sample && hist == '1)
            return 1'b1;
        if (!sample && hist == '0)
            return 1'b0;
        return level;
    endfunction

    function automatic result_t decode_item(input phase_item_t it);
        result_t            r;
        logic [1:0]         prev_ab;
        logic [1:0]         now_ab;
        logic [1:0]         delta;
        logic [COUNT_W:0]   wide;
        logic [COUNT_W-1:0] lim;
        logic [HIT_W-1:0]   hit;
        int                 n_sets;
        hit = HIT_NONE;
        lim = cfg_limit[sel];
        wide = {1'b0, count_store[sel]};
        case (it.command)
            CMD_TICK:
            begin
                prev_ab = settled_ab;
                now_ab = {settle(hist_a, it.phase_a, prev_ab[1]),
                          settle(hist_b, it.phase_b, prev_ab[0])};
                hist_a = {hist_a[HIST_W-2:0], it.phase_a};
                hist_b = {hist_b[HIST_W-2:0], it.phase_b};
                settled_ab = now_ab;
                if (now_ab != prev_ab && cfg_en)
                begin
                    delta = {now_ab[0], now_ab[1] ^ now_ab[0]}
                          - {prev_ab[0], prev_ab[1] ^ prev_ab[0]};
                    if (delta == STEP_UP)
                        wide = wide + 1'b1;
                    else if (delta == STEP_DOWN)
                    begin
                        if (wide == '0)
                            hit = HIT_ZERO;
                        else
                            wide = wide - 1'b1;
                    end
                    if (delta != STEP_BAD && wide > {1'b0, lim})
                    begin
                        wide = {1'b0, lim};
                        hit = HIT_LIMIT;
                    end
                    count_store[sel] = wide[COUNT_W-1:0];
                end
            end
            CMD_LOAD:
            begin
                wide = {1'b0, it.load_value, 2'b00};
                if (wide > {1'b0, lim})
                begin
                    wide = {1'b0, lim};
                    hit = HIT_LIMIT;
                end
                count_store[sel] = wide[COUNT_W-1:0];
            end
            CMD_NEXT:
            begin
                n_sets = (cfg_sets == 0) ? 1 :
                         (cfg_sets > DEF_MAX_SETS) ? DEF_MAX_SETS : int'(cfg_sets);
                if (int'(sel) + 1 >= n_sets)
                    sel = '0;
                else
                    sel = sel + 1'b1;
            end
            default:
            begin
            end
        endcase
        r.raw_count  = count_store[sel];
        r.position   = count_store[sel][COUNT_W-1:2];
        r.active_set = sel;
        r.limit_hit  = hit;
        return r;
    endfunction

    task automatic queue_item(input logic [CMD_W-1:0] cmd, input logic a, input logic b,
                              input logic [LOAD_W-1:0] load);
        phase_item_t it;
        it.command = cmd;
        it.phase_a = a;
        it.phase_b = b;
        it.load_value = load;
        pending_items.push_back(it);
        if (cmd != CMD_UNUSED)
            queued_items++;
    endtask

    task automatic queue_hold(input logic [1:0] ab, input int n);
        repeat (n)
            queue_item(CMD_TICK, ab[1], ab[0], LOAD_W'($urandom_range(0, LOAD_MAX)));
    endtask

    task automatic queue_motion(input int steps, input bit up, input bit noisy);
        logic [1:0] glitch;
        repeat (steps)
        begin
            if (up)
                wheel_ab = {~wheel_ab[0], wheel_ab[1]};
            else
                wheel_ab = {wheel_ab[0], ~wheel_ab[1]};
            if (noisy && $urandom_range(0, 2) == 0)
            begin
                glitch = wheel_ab ^ ($urandom_range(0, 1) ? 2'b10 : 2'b01);
                queue_hold(glitch, $urandom_range(1, 3));
            end
            queue_hold(wheel_ab, noisy ? $urandom_range(1, 6) : $urandom_range(4, 7));
        end
    endtask

    task automatic queue_random_phase(input int n_items);
        int                target;
        int                level;
        logic [LOAD_W-1:0] lv;
        target = queued_items + n_items;
        while (queued_items < target)
        begin
            case ($urandom_range(0, 99)) inside
                [0:59]:  queue_motion($urandom_range(1, 24), 1'($urandom_range(0, 1)), 1'b0);
                [60:69]: queue_motion($urandom_range(1, 12), 1'($urandom_range(0, 1)), 1'b1);
                [70:75]:
                begin
                    repeat ($urandom_range(1, 6))
                        queue_item(CMD_TICK, 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)),
                                   LOAD_W'($urandom_range(0, LOAD_MAX)));
                end
                [76:79]:
                begin
                    wheel_ab = ~wheel_ab;
                    queue_hold(wheel_ab, $urandom_range(4, 6));
                end
                [80:89]:
                begin
                    level = int'(cfg_limit[$urandom_range(0, NUM_LIMITS - 1)]) >> 2;
                    case ($urandom_range(0, 3))
                        0:       level = $urandom_range(0, LOAD_MAX);
                        1:       level = $urandom_range(0, 2);
                        2:       level = level - $urandom_range(0, 3);
                        default: level = level + $urandom_range(0, 2);
                    endcase
                    lv = (level < 0) ? '0 : (level > LOAD_MAX) ? LOAD_W'(LOAD_MAX)
                                                               : LOAD_W'(level);
                    queue_item(CMD_LOAD, 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)), lv);
                end
                [90:95]:
                    queue_item(CMD_NEXT, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               LOAD_W'($urandom_range(0, LOAD_MAX)));
                default:
                    queue_item(CMD_UNUSED, 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)),
                               LOAD_W'($urandom_range(0, LOAD_MAX)));
            endcase
        end
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_SET_COUNT:
                cfg_sets = data[SET_COUNT_W-1:0];
            REG_LIMIT_ZERO, REG_LIMIT_ONE, REG_LIMIT_TWO, REG_LIMIT_THREE:
                cfg_limit[idx - REG_LIMIT_ZERO] = data;
            REG_COUNT_ENABLE:
                cfg_en = data[0];
            default:
            begin
            end
        endcase
    endtask

    task automatic apply_settings(input logic [SET_COUNT_W-1:0] sets,
                                  input logic [COUNT_W-1:0] l0, input logic [COUNT_W-1:0] l1,
                                  input logic [COUNT_W-1:0] l2, input logic [COUNT_W-1:0] l3,
                                  input logic en);
        write_reg(REG_SET_COUNT, CFG_DATA_W'(sets));
        write_reg(REG_LIMIT_ZERO, l0);
        write_reg(REG_LIMIT_ONE, l1);
        write_reg(REG_LIMIT_TWO, l2);
        write_reg(REG_LIMIT_THREE, l3);
        write_reg(REG_COUNT_ENABLE, CFG_DATA_W'(en));
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        setting_count++;
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (holding || pending_items.size() != 0 || expected_results.size() != 0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && phases_if.ready)
            begin
                predicted = decode_item(held_item);
                expected_results.push_back(predicted);
                if (predicted.limit_hit == HIT_ZERO)
                    zero_clamps++;
                if (predicted.limit_hit == HIT_LIMIT)
                    limit_clamps++;
                items_accepted++;
                holding = 0;
                gap_left = quiet_in ? 0 : $urandom_range(0, MAX_WAIT);
                if (items_accepted % 50 == 0)
                    quiet_in = ($urandom_range(0, 2) == 0);
            end
            if (!holding)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    held_item = pending_items.pop_front();
                    holding = 1;
                    in_valid <= 1'b1;
                    in_cmd   <= held_item.command;
                    in_a     <= held_item.phase_a;
                    in_b     <= held_item.phase_b;
                    in_load  <= held_item.load_value;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (result_if.valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("Unexpected result item at %0t: raw %0d set %0d hit %0d",
                                 $time, result_if.raw_count, result_if.active_set,
                                 result_if.limit_hit);
                end
                else
                begin
                    wanted = expected_results.pop_front();
                    if (result_if.position !== wanted.position
                        || result_if.raw_count !== wanted.raw_count
                        || result_if.active_set !== wanted.active_set
                        || result_if.limit_hit !== wanted.limit_hit)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                        begin
                            $display("Mismatch on result item %0d at %0t (expected/actual):",
                                     results_seen, $time);
                            $display("  position %0d/%0d raw %0d/%0d set %0d/%0d hit %0d/%0d",
                                     wanted.position, result_if.position,
                                     wanted.raw_count, result_if.raw_count,
                                     wanted.active_set, result_if.active_set,
                                     wanted.limit_hit, result_if.limit_hit);
                        end
                    end
                end
                results_seen++;
                stall_left = quiet_out ? 0 : $urandom_range(0, MAX_WAIT);
                if (results_seen % 64 == 0)
                    quiet_out = ($urandom_range(0, 2) == 0);
                if (results_seen == 400 || results_seen == 1300)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && phases_if.ready) || (result_if.valid && out_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;

        // Register defaults: one set, limit 65532.
        queue_item(CMD_LOAD, 1'b0, 1'b0, '0);
        queue_hold(2'b00, 1);
        queue_hold(2'b01, 4);
        queue_hold(2'b00, 4);
        queue_item(CMD_LOAD, 1'b1, 1'b1, LOAD_W'(LOAD_MAX));
        queue_hold(2'b10, 4);
        queue_hold(2'b01, 4);
        queue_item(CMD_NEXT, 1'b0, 1'b1, LOAD_W'(LOAD_MAX));
        queue_item(CMD_UNUSED, 1'b1, 1'b1, LOAD_W'(LOAD_MAX));
        queue_item(CMD_LOAD, 1'b0, 1'b0, LOAD_W'(5));
        wheel_ab = 2'b01;
        queue_random_phase(250);
        wait_idle();

        apply_settings(3'd4, 16'd40, 16'd400, 16'd65532, 16'hFFFF, 1'b1);
        queue_random_phase(400);
        wait_idle();

        apply_settings(3'd2, 16'd0, 16'd7, 16'd13, 16'hFFFF, 1'b1);
        queue_random_phase(300);
        wait_idle();

        apply_settings(3'd0, 16'd100, 16'd200, 16'd300, 16'd65532, 1'b0);
        queue_random_phase(200);
        wait_idle();

        apply_settings(3'd7, 16'd65532, 16'd12, 16'd100, 16'd3, 1'b1);
        queue_random_phase(400);
        wait_idle();

        apply_settings(3'd4, 16'd8, 16'd4, 16'd16, 16'd0, 1'b1);
        queue_random_phase(400);
        wait_idle();

        repeat (4)
            @(posedge clk);
        $display("Run covered %0d items and %0d results under %0d register settings,",
                 items_accepted, results_seen, setting_count);
        $display("with %0d steps held at zero and %0d clamps at the limit.",
                 zero_clamps, limit_clamps);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

@@ sim.f @@
design/qdc_pkg.sv
design/qdc_in_if.sv
design/qdc_out_if.sv
design/qdc_filter.sv
design/qdc_core.sv
design/quadrature_decoder_clamped_top.sv
tb/tb_top.sv
